>>> hdl/psg_register_write_translator_defines.svh
// assertion macros shared by the translator modules
`ifndef PSG_REGISTER_WRITE_TRANSLATOR_DEFINES_SVH
`define PSG_REGISTER_WRITE_TRANSLATOR_DEFINES_SVH

// a condition that holds on every cycle out of reset
`define PSG_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// a condition that implies another in the same cycle
`define PSG_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// a condition that implies another in the next cycle
`define PSG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/psg_rwt_pkg.sv
// types, codes and shape table of the sound register translator
package psg_rwt_pkg;

  localparam int NumRegs  = 16;
  localparam int NumCh    = 3;
  localparam int MaxBurst = 10;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic [3:0] REG_NOISE = 4'd6;
  localparam logic [3:0] REG_MIXER = 4'd7;
  localparam logic [3:0] REG_VOL_A = 4'd8;
  localparam logic [3:0] REG_VOL_B = 4'd9;
  localparam logic [3:0] REG_VOL_C = 4'd10;
  localparam logic [3:0] REG_SHAPE = 4'd13;

  localparam logic [7:0] CMD_NOISE_BASE = 8'hF0;
  localparam logic [7:0] CMD_NOISE_OFF  = 8'hFF;
  localparam logic [7:0] CMD_RATE_1     = 8'hE1;
  localparam logic [7:0] CMD_RATE_2     = 8'hE2;
  localparam logic [7:0] CMD_RATE_3     = 8'hE3;
  localparam logic [7:0] CMD_RATE_4     = 8'hE4;
  localparam logic [7:0] CMD_RATE_5     = 8'hE5;
  localparam logic [7:0] CMD_RATE_6     = 8'hE6;
  localparam logic [7:0] CMD_ATT_OFF    = 8'h1F;
  localparam logic [10:0] PERIOD_MAX    = 11'h7FF;

  // shape half kinds
  localparam logic [1:0] KIND_ZERO = 2'd0;
  localparam logic [1:0] KIND_FALL = 2'd1;
  localparam logic [1:0] KIND_RISE = 2'd2;
  localparam logic [1:0] KIND_FULL = 2'd3;

  typedef logic [7:0] cmd_t;

  typedef struct packed {
    logic [MaxBurst-1:0][7:0] bytes;
    logic [3:0]               count;
  } burst_t;

  function automatic logic [3:0] shape_level(logic [3:0] shape, logic [4:0] pos);
    logic [1:0] kind;
    kind = KIND_ZERO;
    if (!pos[4]) begin
      kind = shape[2] ? KIND_RISE : KIND_FALL;
    end else begin
      unique case (shape)
        4'd8:    kind = KIND_FALL;
        4'd10:   kind = KIND_RISE;
        4'd11:   kind = KIND_FULL;
        4'd12:   kind = KIND_RISE;
        4'd13:   kind = KIND_FULL;
        4'd14:   kind = KIND_FALL;
        default: kind = KIND_ZERO;
      endcase
    end
    unique case (kind)
      KIND_FALL: return ~pos[3:0];
      KIND_RISE: return pos[3:0];
      KIND_FULL: return 4'hF;
      default:   return 4'h0;
    endcase
  endfunction

  function automatic cmd_t rate_byte(logic [4:0] p);
    if (p > 5'd28)      return CMD_RATE_6;
    else if (p > 5'd20) return CMD_RATE_5;
    else if (p > 5'd12) return CMD_RATE_4;
    else if (p > 5'd8)  return CMD_RATE_3;
    else if (p > 5'd4)  return CMD_RATE_2;
    else                return CMD_RATE_1;
  endfunction

endpackage

>>> hdl/psg_rwt_if.sv
// input and output channel interfaces of the translator
interface psg_rwt_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [3:0] reg_index;
  logic [7:0] value;

  modport source (output valid, operation, reg_index, value, input ready);
  modport sink (input valid, operation, reg_index, value, output ready);
endinterface

interface psg_rwt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] sn_command;
  logic       last;

  modport source (output valid, sn_command, last, input ready);
  modport sink (input valid, sn_command, last, output ready);
endinterface

>>> hdl/psg_register_write_translator.sv
// top level of the sound register write translator
//
//  channel  dir  handshake      payload
//  in_ch    in   valid/ready    operation, reg_index, value
//  out_ch   out  valid/ready    sn_command, last
//  cfg      in   cfg_we         cfg_wdata (envelope_keep_position)
//
// an item is registered on accept, its burst goes to the serialiser once that is ready
// the first command byte is offered once the burst is loaded, then one byte a cycle unless out_ch stalls
// an item with n command bytes holds the serialiser until all n are taken; items with none
// never load it, so the rate is set by burst length (up to ten bytes per item)
// rst is synchronous and clears the register file, envelope positions and both stages
// one item waits in the input register while a burst drains; stalls on out_ch hold bytes
module psg_register_write_translator (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic           cfg_wdata,
  psg_rwt_in_if.sink     in_ch,
  psg_rwt_out_if.source  out_ch
);
  import psg_rwt_pkg::*;

  burst_t burst;
  logic   burst_valid;
  logic   burst_ready;

  psg_rwt_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_ch       (in_ch),
    .burst       (burst),
    .burst_valid (burst_valid),
    .burst_ready (burst_ready)
  );

  psg_rwt_out u_out (
    .clk         (clk),
    .rst         (rst),
    .burst       (burst),
    .burst_valid (burst_valid),
    .burst_ready (burst_ready),
    .out_ch      (out_ch)
  );

endmodule

>>> hdl/psg_rwt_core.sv
// input register, sound register file, envelope positions and burst builder
`include "psg_register_write_translator_defines.svh"

module psg_rwt_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic                 cfg_wdata,
  psg_rwt_in_if.sink           in_ch,
  output psg_rwt_pkg::burst_t  burst,
  output logic                 burst_valid,
  input  logic                 burst_ready
);
  import psg_rwt_pkg::*;

  logic       keep_pos;
  logic       s0_valid;
  logic       s0_op;
  logic [3:0] s0_idx;
  logic [7:0] s0_val;
  logic       s0_go;

  logic [7:0] rf      [NumRegs];
  logic [7:0] rf_next [NumRegs];
  logic [4:0] env_pos      [NumCh];
  logic [4:0] env_pos_next [NumCh];

  logic [3:0] lvl     [NumCh];
  logic [NumCh-1:0] changed;
  logic       is_vol;

  cmd_t       tb [NumCh][3];
  logic [3:0] tl [NumCh];
  cmd_t       nb;
  logic [1:0] sel_ch;
  logic [3:0] all_count;
  logic [MaxBurst-1:0][7:0] all_bytes;
  logic [MaxBurst-1:0][7:0] one_bytes;

  assign s0_go       = s0_valid && (burst.count == 4'd0 || burst_ready);
  assign in_ch.ready = !s0_valid || s0_go;
  assign burst_valid = s0_valid && burst.count != 4'd0;
  assign is_vol      = s0_idx == REG_VOL_A || s0_idx == REG_VOL_B || s0_idx == REG_VOL_C;

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_pos <= 1'b0;
    end else if (cfg_we) begin
      keep_pos <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s0_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s0_op  <= in_ch.operation;
      s0_idx <= in_ch.reg_index;
      s0_val <= in_ch.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < NumRegs; r++) begin
        rf[r] <= 8'h00;
      end
      for (int c = 0; c < NumCh; c++) begin
        env_pos[c] <= 5'd0;
      end
    end else if (s0_go) begin
      rf      <= rf_next;
      env_pos <= env_pos_next;
    end
  end

  // state after this item
  always_comb begin
    rf_next      = rf;
    env_pos_next = env_pos;
    for (int c = 0; c < NumCh; c++) begin
      lvl[c]     = shape_level(rf[REG_SHAPE][3:0], env_pos[c]);
      changed[c] = rf[4'(8 + c)][4] && lvl[c] != rf[4'(8 + c)][3:0];
    end
    if (s0_op == OP_TICK) begin
      for (int c = 0; c < NumCh; c++) begin
        if (rf[4'(8 + c)][4]) begin
          rf_next[4'(8 + c)][3:0] = lvl[c];
          if (env_pos[c] == 5'd31) begin
            env_pos_next[c] = (rf[REG_SHAPE][3] && !rf[REG_SHAPE][0]) ? 5'd0 : 5'd31;
          end else begin
            env_pos_next[c] = env_pos[c] + 5'd1;
          end
        end
      end
    end else begin
      rf_next[s0_idx] = s0_val;
      if (is_vol && s0_val[4]) begin
        // envelope enable keeps only the bits set in both nibbles
        rf_next[s0_idx] = {s0_val[7:4], s0_val[3:0] & rf[s0_idx][3:0]};
        if (!keep_pos) begin
          env_pos_next[s0_idx[1:0]] = 5'd0;
        end
      end
      if (s0_idx == REG_SHAPE) begin
        for (int c = 0; c < NumCh; c++) begin
          env_pos_next[c] = 5'd0;
        end
      end
    end
  end

  // tone and noise bytes from the updated registers
  always_comb begin
    logic [10:0] per;
    logic [7:0]  base;
    logic [3:0]  vol;
    nb = CMD_NOISE_OFF;
    for (int c = 0; c < NumCh; c++) begin
      base = {1'b1, 2'(c), 5'b0};
      vol  = rf_next[4'(8 + c)][3:0];
      per  = rf_next[4'(2 * c + 1)][3] ? PERIOD_MAX
                                       : {rf_next[4'(2 * c + 1)][2:0], rf_next[4'(2 * c)]};
      if (rf_next[REG_MIXER][c]) begin
        tl[c]    = 4'd1;
        tb[c][0] = base | CMD_ATT_OFF;
      end else begin
        tl[c]    = 4'd3;
        tb[c][0] = base | {4'h0, per[3:0]};
      end
      tb[c][1] = {1'b0, per[10:4]};
      tb[c][2] = (per != 11'd0) ? (base | {4'h1, ~vol}) : (base | CMD_ATT_OFF);
    end
    // channel a has priority, so scan from c downwards
    for (int c = NumCh - 1; c >= 0; c--) begin
      vol = rf_next[4'(8 + c)][3:0];
      if (!rf_next[REG_MIXER][3 + c] && vol != 4'd0) begin
        nb = CMD_NOISE_BASE | {4'h0, ~vol};
      end
    end
  end

  // pack variable-length tone groups and the noise byte into the burst
  always_comb begin
    logic [3:0] e0;
    logic [3:0] e1;
    logic [3:0] e2;
    logic [3:0] k;
    k         = 4'd0;
    e0        = tl[0];
    e1        = tl[0] + tl[1];
    e2        = e1 + tl[2];
    all_count = e2 + 4'd1;
    sel_ch    = (s0_idx == REG_VOL_A || s0_idx == REG_VOL_B || s0_idx == REG_VOL_C)
                ? s0_idx[1:0] : s0_idx[2:1];
    for (int i = 0; i < MaxBurst; i++) begin
      all_bytes[i] = 8'h00;
      one_bytes[i] = 8'h00;
      if (4'(i) < e0) begin
        k            = 4'(i);
        all_bytes[i] = tb[0][k[1:0]];
      end else if (4'(i) < e1) begin
        k            = 4'(i) - e0;
        all_bytes[i] = tb[1][k[1:0]];
      end else if (4'(i) < e2) begin
        k            = 4'(i) - e1;
        all_bytes[i] = tb[2][k[1:0]];
      end else if (4'(i) == e2) begin
        all_bytes[i] = nb;
      end
      if (4'(i) < tl[sel_ch]) begin
        k            = 4'(i);
        one_bytes[i] = tb[sel_ch][k[1:0]];
      end else if (4'(i) == tl[sel_ch]) begin
        one_bytes[i] = nb;
      end
    end
  end

  always_comb begin
    burst.bytes = '0;
    burst.count = 4'd0;
    if (s0_op == OP_TICK) begin
      if (changed != '0) begin
        burst.bytes = all_bytes;
        burst.count = all_count;
      end
    end else begin
      unique case (s0_idx)
        4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5: begin
          burst.bytes = one_bytes;
          burst.count = tl[sel_ch];
        end
        REG_NOISE: begin
          burst.bytes[0] = rate_byte(s0_val[4:0]);
          burst.bytes[1] = nb;
          burst.count    = 4'd2;
        end
        REG_MIXER: begin
          burst.bytes = all_bytes;
          burst.count = all_count;
        end
        REG_VOL_A, REG_VOL_B, REG_VOL_C: begin
          if (!s0_val[4]) begin
            burst.bytes = one_bytes;
            burst.count = tl[sel_ch] + 4'd1;
          end
        end
        default: begin
          burst.count = 4'd0;
        end
      endcase
    end
  end

  `PSG_ASSERT_NEXT(a_s0_hold, s0_valid && !s0_go, s0_valid && $stable(s0_idx), "stalled item lost")
  `PSG_ASSERT_SAME(a_count_max, s0_valid, burst.count <= 4'd10, "burst longer than ten")
  `PSG_ASSERT_SAME(a_shape_silent, s0_valid && s0_op == OP_WRITE && s0_idx == REG_SHAPE,
                   burst.count == 4'd0, "shape write produced commands")

endmodule

>>> hdl/psg_rwt_out.sv
// burst serialiser: sends one command byte a cycle while out_ch is ready, flags the last
`include "psg_register_write_translator_defines.svh"

module psg_rwt_out (
  input  logic                 clk,
  input  logic                 rst,
  input  psg_rwt_pkg::burst_t  burst,
  input  logic                 burst_valid,
  output logic                 burst_ready,
  psg_rwt_out_if.source        out_ch
);
  import psg_rwt_pkg::*;

  logic [MaxBurst-1:0][7:0] em_bytes;
  logic [3:0]               em_left;
  logic                     take;

  assign take              = out_ch.valid && out_ch.ready;
  assign out_ch.valid      = em_left != 4'd0;
  assign out_ch.sn_command = em_bytes[0];
  assign out_ch.last       = em_left == 4'd1;
  assign burst_ready       = em_left == 4'd0 || (em_left == 4'd1 && out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      em_left <= 4'd0;
    end else if (burst_valid && burst_ready) begin
      em_left <= burst.count;
    end else if (take) begin
      em_left <= em_left - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (burst_valid && burst_ready) begin
      em_bytes <= burst.bytes;
    end else if (take) begin
      em_bytes <= {8'h00, em_bytes[MaxBurst-1:1]};
    end
  end

  `PSG_ASSERT_NEXT(a_load, burst_valid && burst_ready, em_left == $past(burst.count),
                   "burst not loaded")
  `PSG_ASSERT_NEXT(a_step, take && em_left > 4'd1, em_left == $past(em_left) - 4'd1,
                   "byte count did not step")
  `PSG_ASSERT_ALWAYS(a_left_max, em_left <= 4'd10, "byte count out of range")

endmodule

>>> tb/sv/testbench.sv
// testbench of the sound register write translator: directed table, random phases, predictor
`timescale 1ns / 100ps

module testbench;
  import psg_rwt_pkg::*;

  localparam int LIMIT_CYCLES = 200000;

  localparam logic [3:0] REG_PERIOD_A_LO = 4'd0;
  localparam logic [3:0] REG_PERIOD_A_HI = 4'd1;
  localparam logic [3:0] REG_PERIOD_B_LO = 4'd2;
  localparam logic [3:0] REG_PERIOD_B_HI = 4'd3;
  localparam logic [3:0] REG_PERIOD_C_LO = 4'd4;
  localparam logic [3:0] REG_PERIOD_C_HI = 4'd5;
  localparam logic [3:0] REG_ENV_FINE    = 4'd11;
  localparam logic [3:0] REG_ENV_COARSE  = 4'd12;
  localparam logic [3:0] REG_PORT_A      = 4'd14;
  localparam logic [3:0] REG_PORT_B      = 4'd15;

  localparam logic [7:0] TONE_BASE = 8'h80;
  localparam logic [7:0] ATT_FLAG  = 8'h10;
  localparam logic [4:0] POS_END   = 5'd31;

  typedef struct packed {
    cmd_t cmd;
    logic last;
  } sn_cmd_t;

  typedef struct packed {
    logic            op;
    logic [3:0]      idx;
    logic [7:0]      val;
    logic            typed;
    logic [2:0]      n_typed;
    logic [0:3][7:0] cmds;
  } dir_row_t;

  localparam logic [0:3][7:0] NO_CMDS = 32'h0;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;
  logic hold;
  logic calm;

  psg_rwt_in_if  in_ch ();
  psg_rwt_out_if out_ch ();

  psg_register_write_translator u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // predictor state
  logic [7:0] psg_regs [NumRegs];
  logic [4:0] env_pos [NumCh];
  logic       keep_pos;

  cmd_t    burst_cmds [$];
  sn_cmd_t pending_cmds [$];
  int      mismatch_count = 0;
  int      items_sent = 0;
  int      cycle_count = 0;

  // rows with typed commands are checked against those, the rest against the predictor
  dir_row_t dir_rows [0:24] = '{
    '{OP_WRITE, REG_PERIOD_A_LO, 8'h00, 1'b1, 3'd3, {8'h80, 8'h00, 8'h9F, 8'h00}},
    '{OP_WRITE, REG_NOISE,       8'h1F, 1'b1, 3'd2, {CMD_RATE_6, CMD_NOISE_OFF, 16'h0}},
    '{OP_WRITE, REG_NOISE,       8'hE0, 1'b1, 3'd2, {CMD_RATE_1, CMD_NOISE_OFF, 16'h0}},
    '{OP_WRITE, REG_ENV_FINE,    8'hFF, 1'b1, 3'd0, NO_CMDS},
    '{OP_WRITE, REG_PERIOD_A_HI, 8'hFF, 1'b1, 3'd3, {8'h8F, 8'h7F, 8'h9F, 8'h00}},
    '{OP_WRITE, REG_VOL_A,       8'h0F, 1'b1, 3'd4, {8'h8F, 8'h7F, 8'h90, 8'hF0}},
    '{OP_WRITE, REG_MIXER,       8'hFF, 1'b1, 3'd4, {8'h9F, 8'hBF, 8'hDF, 8'hFF}},
    '{OP_WRITE, REG_MIXER,       8'h00, 1'b0, 3'd0, NO_CMDS},
    '{OP_WRITE, REG_PERIOD_B_LO, 8'h34, 1'b0, 3'd0, NO_CMDS},
    '{OP_WRITE, REG_PERIOD_B_HI, 8'h05, 1'b0, 3'd0, NO_CMDS},
    '{OP_WRITE, REG_PERIOD_C_HI, 8'h07, 1'b0, 3'd0, NO_CMDS},
    '{OP_WRITE, REG_PERIOD_C_LO, 8'hFF, 1'b0, 3'd0, NO_CMDS},
    '{OP_WRITE, REG_VOL_B,       8'h05, 1'b0, 3'd0, NO_CMDS},
    '{OP_WRITE, REG_VOL_C,       8'h0A, 1'b0, 3'd0, NO_CMDS},
    '{OP_WRITE, REG_SHAPE,       8'h08, 1'b1, 3'd0, NO_CMDS},
    '{OP_WRITE, REG_VOL_A,       8'h10, 1'b1, 3'd0, NO_CMDS},
    '{OP_TICK,  4'd0,            8'h00, 1'b0, 3'd0, NO_CMDS},
    '{OP_WRITE, REG_VOL_B,       8'h1F, 1'b0, 3'd0, NO_CMDS},
    '{OP_WRITE, REG_VOL_C,       8'h1E, 1'b0, 3'd0, NO_CMDS},
    '{OP_TICK,  4'd0,            8'h00, 1'b0, 3'd0, NO_CMDS},
    '{OP_WRITE, REG_NOISE,       8'h0D, 1'b0, 3'd0, NO_CMDS},
    '{OP_WRITE, REG_NOISE,       8'h35, 1'b0, 3'd0, NO_CMDS},
    '{OP_WRITE, REG_NOISE,       8'h05, 1'b0, 3'd0, NO_CMDS},
    '{OP_WRITE, REG_ENV_COARSE,  8'hAA, 1'b0, 3'd0, NO_CMDS},
    '{OP_TICK,  4'hF,            8'hFF, 1'b0, 3'd0, NO_CMDS}
  };

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // second half of the shape: continue, alternate and hold pick the level
  function automatic logic [3:0] env_level(logic [3:0] shape, logic [4:0] pos);
    if (!pos[4]) return shape[2] ? pos[3:0] : ~pos[3:0];
    if (!shape[3]) return 4'h0;
    case (shape[2:0])
      3'd0, 3'd6: return ~pos[3:0];
      3'd2, 3'd4: return pos[3:0];
      3'd3, 3'd5: return 4'hF;
      default:    return 4'h0;
    endcase
  endfunction

  function automatic void tone_cmds(int ch);
    logic [7:0]  base;
    logic [11:0] per_raw;
    logic [10:0] per;
    logic [3:0]  vol;
    base    = TONE_BASE + 8'(ch * 32);
    vol     = psg_regs[8 + ch][3:0];
    per_raw = {psg_regs[2 * ch + 1][3:0], psg_regs[2 * ch]};
    per     = per_raw[11] ? PERIOD_MAX : per_raw[10:0];
    if (psg_regs[REG_MIXER][ch]) begin
      burst_cmds.push_back(base | CMD_ATT_OFF);
    end else begin
      burst_cmds.push_back(base | {4'h0, per[3:0]});
      burst_cmds.push_back({1'b0, per[10:4]});
      burst_cmds.push_back((per != 11'd0) ? (base | ATT_FLAG | {4'h0, ~vol})
                                          : (base | CMD_ATT_OFF));
    end
  endfunction

  // lowest channel with noise on and some volume wins
  function automatic void noise_cmd();
    cmd_t       cmd;
    logic [3:0] vol;
    cmd = CMD_NOISE_OFF;
    for (int ch = NumCh - 1; ch >= 0; ch--) begin
      vol = psg_regs[8 + ch][3:0];
      if (!psg_regs[REG_MIXER][3 + ch] && vol != 4'h0) cmd = CMD_NOISE_BASE | {4'h0, ~vol};
    end
    burst_cmds.push_back(cmd);
  endfunction

  function automatic logic env_step(int ch, logic [3:0] shape);
    logic [3:0] lvl;
    logic       moved;
    if (!psg_regs[8 + ch][4]) return 1'b0;
    lvl   = env_level(shape, env_pos[ch]);
    moved = lvl != psg_regs[8 + ch][3:0];
    psg_regs[8 + ch][3:0] = lvl;
    if (env_pos[ch] != POS_END) env_pos[ch] = env_pos[ch] + 5'd1;
    else if (shape[3] && !shape[0]) env_pos[ch] = 5'd0;
    return moved;
  endfunction

  function automatic void translate_item(logic op, logic [3:0] idx, logic [7:0] val);
    logic [7:0] prev;
    logic [4:0] rate;
    logic       moved;
    int         ch;
    burst_cmds.delete();
    if (op == OP_TICK) begin
      moved = 1'b0;
      for (int c = 0; c < NumCh; c++) moved = env_step(c, psg_regs[REG_SHAPE][3:0]) | moved;
      if (moved) begin
        for (int c = 0; c < NumCh; c++) tone_cmds(c);
        noise_cmd();
      end
      return;
    end
    prev = psg_regs[idx];
    psg_regs[idx] = val;
    case (idx)
      REG_PERIOD_A_LO, REG_PERIOD_A_HI: tone_cmds(0);
      REG_PERIOD_B_LO, REG_PERIOD_B_HI: tone_cmds(1);
      REG_PERIOD_C_LO, REG_PERIOD_C_HI: tone_cmds(2);
      REG_NOISE: begin
        rate = val[4:0];
        if (rate <= 5'd4)       burst_cmds.push_back(CMD_RATE_1);
        else if (rate <= 5'd8)  burst_cmds.push_back(CMD_RATE_2);
        else if (rate <= 5'd12) burst_cmds.push_back(CMD_RATE_3);
        else if (rate <= 5'd20) burst_cmds.push_back(CMD_RATE_4);
        else if (rate <= 5'd28) burst_cmds.push_back(CMD_RATE_5);
        else                    burst_cmds.push_back(CMD_RATE_6);
        noise_cmd();
      end
      REG_MIXER: begin
        for (int c = 0; c < NumCh; c++) tone_cmds(c);
        noise_cmd();
      end
      REG_VOL_A, REG_VOL_B, REG_VOL_C: begin
        ch = int'(idx - REG_VOL_A);
        if (val[4]) begin
          // envelope on: level can only drop bits of the old one
          if (!keep_pos) env_pos[ch] = 5'd0;
          psg_regs[idx] = val & {4'hF, prev[3:0]};
        end else begin
          tone_cmds(ch);
          noise_cmd();
        end
      end
      REG_SHAPE: for (int c = 0; c < NumCh; c++) env_pos[c] = 5'd0;
      default: ;
    endcase
  endfunction

  function automatic dir_row_t random_item(logic env_run);
    dir_row_t row;
    int       pick;
    int       tick_pct;
    int       vol_pct;
    int       shape_pct;
    row       = '0;
    row.op    = OP_WRITE;
    row.idx   = 4'($urandom);
    row.val   = 8'($urandom);
    tick_pct  = env_run ? 78 : 28;
    vol_pct   = env_run ? 8 : 24;
    shape_pct = env_run ? 1 : 8;
    pick      = $urandom_range(0, 99);
    if (pick < tick_pct) begin
      row.op = OP_TICK;
    end else if (pick < tick_pct + vol_pct) begin
      row.idx    = REG_VOL_A + 4'($urandom_range(0, 2));
      row.val[4] = $urandom_range(0, 9) < 7;
    end else if (pick < tick_pct + vol_pct + shape_pct) begin
      row.idx = REG_SHAPE;
    end else begin
      case ($urandom_range(0, 9))
        0, 1: begin
          row.idx = REG_MIXER;
          // lean towards enabled tones and noise
          if ($urandom_range(0, 1)) row.val = row.val & 8'($urandom);
        end
        2, 3:    row.idx = REG_NOISE;
        9: begin
          case ($urandom_range(0, 3))
            0:       row.idx = REG_ENV_FINE;
            1:       row.idx = REG_ENV_COARSE;
            2:       row.idx = REG_PORT_A;
            default: row.idx = REG_PORT_B;
          endcase
        end
        default: row.idx = REG_PERIOD_A_LO + 4'($urandom_range(0, 5));
      endcase
    end
    return row;
  endfunction

  task automatic flag_mismatch(string what, logic [7:0] got, logic [7:0] want);
    mismatch_count++;
    $display("%0t mismatch on %s: got %h, want %h", $time, what, got, want);
  endtask

  // valid is left high after the accept so back-to-back items need no second assignment
  task automatic send_item(dir_row_t row);
    int      gap;
    sn_cmd_t entry;
    gap = 0;
    while (!calm && $urandom_range(0, 99) < 14) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= row.op;
    in_ch.reg_index <= row.idx;
    in_ch.value     <= row.val;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    translate_item(row.op, row.idx, row.val);
    if (row.typed) begin
      burst_cmds.delete();
      for (int i = 0; i < row.n_typed; i++) burst_cmds.push_back(row.cmds[i]);
    end
    foreach (burst_cmds[i]) begin
      entry.cmd  = burst_cmds[i];
      entry.last = i == burst_cmds.size() - 1;
      pending_cmds.push_back(entry);
    end
    items_sent++;
  endtask

  // items with no commands may still be in flight, so wait on after the queue is empty
  task automatic drain();
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_keep(logic keep);
    cfg_we    <= 1'b1;
    cfg_wdata <= keep;
    @(posedge clk);
    cfg_we    <= 1'b0;
    keep_pos   = keep;
  endtask

  task automatic run_phase(logic keep, logic env_run, logic quiet, int n_items);
    drain();
    write_keep(keep);
    calm <= quiet;
    for (int i = 0; i < n_items; i++) begin
      send_item(random_item(env_run));
      if (i == n_items / 2) begin
        in_ch.valid <= 1'b0;
        drain();
      end
    end
    in_ch.valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    sn_cmd_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_cmds.size() == 0) begin
        flag_mismatch("command with none pending", out_ch.sn_command, 8'h00);
      end else begin
        want = pending_cmds.pop_front();
        if (out_ch.sn_command !== want.cmd)
          flag_mismatch("sn_command", out_ch.sn_command, want.cmd);
        if (out_ch.last !== want.last)
          flag_mismatch("last", {7'h0, out_ch.last}, {7'h0, want.last});
      end
    end
    out_ch.ready <= !rst && !hold && (calm || $urandom_range(0, 99) >= 14);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  // long receiver stall while items keep coming, so the input backs up
  initial begin
    hold = 1'b0;
    wait (items_sent >= 60);
    @(posedge clk);
    hold <= 1'b1;
    repeat (300) @(posedge clk);
    hold <= 1'b0;
  end

  initial begin
    rst             = 1'b1;
    calm            = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.operation = OP_WRITE;
    in_ch.reg_index = 4'd0;
    in_ch.value     = 8'h00;
    out_ch.ready    = 1'b0;
    foreach (psg_regs[i]) psg_regs[i] = 8'h00;
    foreach (env_pos[i]) env_pos[i] = 5'd0;
    keep_pos = 1'b0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_keep(1'b0);

    foreach (dir_rows[i]) send_item(dir_rows[i]);
    in_ch.valid <= 1'b0;

    run_phase(1'b1, 1'b0, 1'b0, 130);
    run_phase(1'b0, 1'b1, 1'b1, 120);
    run_phase(1'b1, 1'b1, 1'b0, 120);
    run_phase(1'b0, 1'b0, 1'b0, 110);

    drain();
    repeat (14) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
